>>> rtl/iadp_pkg.sv
// ============================================================================
// Integer ALU decimal print package
// Shared item types, operation codes, sequencer states and message text.
// ============================================================================
package iadp_pkg;

    localparam int DATA_W  = 32;
    localparam int CNT_W   = 5;
    localparam int DIGITS  = 10;
    localparam int DIG_W   = 4;
    localparam int IDX_W   = 5;
    localparam int DIV_LEN = 23;
    localparam int MOD_LEN = 21;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_MOD = 3'd4;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [8*DIV_LEN-1:0] DIV_MSG = "Stop : division by zero";
    localparam logic [8*MOD_LEN-1:0] MOD_MSG = "Stop : modulo by zero";

    typedef struct packed {
        logic        [2:0]        cmd;
        logic signed [DATA_W-1:0] left_operand;
        logic signed [DATA_W-1:0] right_operand;
    } t_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } t_out;

    typedef struct packed {
        logic              done;
        logic              neg;
        logic [DATA_W-1:0] mag;
    } t_ar_res;

    typedef struct packed {
        logic                    done;
        logic [DIG_W-1:0]        top;
        logic [DIGITS*DIG_W-1:0] digits;
    } t_bcd_res;

    typedef enum logic [2:0] {
        AR_IDLE,
        AR_ABSA,
        AR_ABSB,
        AR_RUN,
        AR_FIX,
        AR_MAG
    } t_ar_state;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARITH,
        ST_CONV,
        ST_SIGN,
        ST_DIGIT,
        ST_MSG,
        ST_NL
    } t_state;

    function automatic logic [7:0] msg_char(input logic is_mod, input logic [IDX_W-1:0] idx);
        int unsigned pos;
        logic [7:0]  ch;
        if (is_mod) begin
            pos = 8 * (MOD_LEN - 1 - int'(idx));
            ch  = MOD_MSG[pos +: 8];
        end else begin
            pos = 8 * (DIV_LEN - 1 - int'(idx));
            ch  = DIV_MSG[pos +: 8];
        end
        return ch;
    endfunction

    function automatic logic [IDX_W-1:0] msg_last(input logic is_mod);
        return is_mod ? IDX_W'(MOD_LEN - 1) : IDX_W'(DIV_LEN - 1);
    endfunction

endpackage

>>> rtl/iadp_arith.sv
// ============================================================================
// Iterative arithmetic unit
// One shared 33-bit adder performs add, subtract, shift-add multiply,
// restoring divide, sign fixing and the final magnitude step.
// ============================================================================
module iadp_arith (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  iadp_pkg::t_in                i_item,
    output iadp_pkg::t_ar_res            o_res
);

    iadp_pkg::t_ar_state r_state, n_state;

    logic [2:0]                    r_cmd;
    logic [iadp_pkg::DATA_W-1:0]   r_acc, r_q, r_m, r_res, r_mag;
    logic [iadp_pkg::CNT_W-1:0]    r_cnt;
    logic                          r_aneg, r_bneg, r_neg, r_done;

    logic [iadp_pkg::DATA_W:0]     add_x, add_y;
    logic                          add_sub;
    logic [iadp_pkg::DATA_W+1:0]   sum;
    logic                          is_mul;

    assign is_mul = (r_cmd == iadp_pkg::CMD_MUL);
    assign sum    = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                  + {{(iadp_pkg::DATA_W+1){1'b0}}, add_sub};

    always_comb begin
        n_state = r_state;
        case (r_state)
            iadp_pkg::AR_IDLE: begin
                if (i_go) begin
                    case (i_item.cmd)
                        iadp_pkg::CMD_MUL: n_state = iadp_pkg::AR_RUN;
                        iadp_pkg::CMD_DIV,
                        iadp_pkg::CMD_MOD: n_state = iadp_pkg::AR_ABSA;
                        default:           n_state = iadp_pkg::AR_FIX;
                    endcase
                end
            end
            iadp_pkg::AR_ABSA: n_state = iadp_pkg::AR_ABSB;
            iadp_pkg::AR_ABSB: n_state = iadp_pkg::AR_RUN;
            iadp_pkg::AR_RUN: begin
                if (r_cnt == {iadp_pkg::CNT_W{1'b1}}) begin
                    n_state = iadp_pkg::AR_FIX;
                end
            end
            iadp_pkg::AR_FIX:  n_state = iadp_pkg::AR_MAG;
            iadp_pkg::AR_MAG:  n_state = iadp_pkg::AR_IDLE;
            default:           n_state = iadp_pkg::AR_IDLE;
        endcase
    end

    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        case (r_state)
            iadp_pkg::AR_ABSA: begin
                add_y   = {1'b0, r_q};
                add_sub = r_aneg;
            end
            iadp_pkg::AR_ABSB: begin
                add_y   = {1'b0, r_m};
                add_sub = r_bneg;
            end
            iadp_pkg::AR_RUN: begin
                if (is_mul) begin
                    add_x = {1'b0, r_acc};
                    add_y = {1'b0, r_m};
                end else begin
                    add_x   = {r_acc, r_q[iadp_pkg::DATA_W-1]};
                    add_y   = {1'b0, r_m};
                    add_sub = 1'b1;
                end
            end
            iadp_pkg::AR_FIX: begin
                case (r_cmd)
                    iadp_pkg::CMD_ADD: begin
                        add_x = {1'b0, r_q};
                        add_y = {1'b0, r_m};
                    end
                    iadp_pkg::CMD_SUB: begin
                        add_x   = {1'b0, r_q};
                        add_y   = {1'b0, r_m};
                        add_sub = 1'b1;
                    end
                    iadp_pkg::CMD_DIV: begin
                        add_y   = {1'b0, r_q};
                        add_sub = r_aneg ^ r_bneg;
                    end
                    iadp_pkg::CMD_MOD: begin
                        add_y   = {1'b0, r_acc};
                        add_sub = r_aneg;
                    end
                    default: begin
                        add_y = {1'b0, r_acc};
                    end
                endcase
            end
            iadp_pkg::AR_MAG: begin
                add_y   = {1'b0, r_res};
                add_sub = r_res[iadp_pkg::DATA_W-1];
            end
            default: begin
                add_x = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iadp_pkg::AR_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == iadp_pkg::AR_MAG);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            iadp_pkg::AR_IDLE: begin
                r_cmd  <= i_item.cmd;
                r_acc  <= '0;
                r_q    <= i_item.left_operand;
                r_m    <= i_item.right_operand;
                r_cnt  <= '0;
                r_aneg <= i_item.left_operand[iadp_pkg::DATA_W-1];
                r_bneg <= i_item.right_operand[iadp_pkg::DATA_W-1];
            end
            iadp_pkg::AR_ABSA: r_q <= sum[iadp_pkg::DATA_W-1:0];
            iadp_pkg::AR_ABSB: r_m <= sum[iadp_pkg::DATA_W-1:0];
            iadp_pkg::AR_RUN: begin
                r_cnt <= r_cnt + 1'b1;
                if (is_mul) begin
                    if (r_q[0]) begin
                        r_acc <= sum[iadp_pkg::DATA_W-1:0];
                    end
                    r_m <= {r_m[iadp_pkg::DATA_W-2:0], 1'b0};
                    r_q <= {1'b0, r_q[iadp_pkg::DATA_W-1:1]};
                end else begin
                    r_acc <= sum[iadp_pkg::DATA_W+1] ? sum[iadp_pkg::DATA_W-1:0]
                                                     : add_x[iadp_pkg::DATA_W-1:0];
                    r_q   <= {r_q[iadp_pkg::DATA_W-2:0], sum[iadp_pkg::DATA_W+1]};
                end
            end
            iadp_pkg::AR_FIX: r_res <= sum[iadp_pkg::DATA_W-1:0];
            iadp_pkg::AR_MAG: begin
                r_mag <= sum[iadp_pkg::DATA_W-1:0];
                r_neg <= r_res[iadp_pkg::DATA_W-1];
            end
            default: r_cnt <= '0;
        endcase
    end

    assign o_res.done = r_done;
    assign o_res.neg  = r_neg;
    assign o_res.mag  = r_mag;

endmodule

>>> rtl/iadp_bcd.sv
// ============================================================================
// Binary to decimal converter
// Shift-and-add-three conversion of a 32-bit magnitude, one bit per cycle.
// ============================================================================
module iadp_bcd (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [iadp_pkg::DATA_W-1:0]   i_mag,
    output iadp_pkg::t_bcd_res            o_res
);

    localparam int BCD_W = iadp_pkg::DIGITS * iadp_pkg::DIG_W;

    logic [iadp_pkg::DATA_W-1:0] r_sh;
    logic [BCD_W-1:0]            r_dig, adj;
    logic [iadp_pkg::CNT_W-1:0]  r_cnt;
    logic                        r_busy, r_done;
    logic [iadp_pkg::DIG_W-1:0]  top;

    always_comb begin
        for (int i = 0; i < iadp_pkg::DIGITS; i++) begin
            adj[i*iadp_pkg::DIG_W +: iadp_pkg::DIG_W] =
                (r_dig[i*iadp_pkg::DIG_W +: iadp_pkg::DIG_W] >= 4'd5)
                ? r_dig[i*iadp_pkg::DIG_W +: iadp_pkg::DIG_W] + 4'd3
                : r_dig[i*iadp_pkg::DIG_W +: iadp_pkg::DIG_W];
        end
    end

    always_comb begin
        top = '0;
        for (int i = 0; i < iadp_pkg::DIGITS; i++) begin
            if (r_dig[i*iadp_pkg::DIG_W +: iadp_pkg::DIG_W] != '0) begin
                top = iadp_pkg::DIG_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == {iadp_pkg::CNT_W{1'b1}});
            if (i_go) begin
                r_busy <= 1'b1;
            end else if (r_cnt == {iadp_pkg::CNT_W{1'b1}}) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_sh  <= i_mag;
            r_dig <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_sh  <= {r_sh[iadp_pkg::DATA_W-2:0], 1'b0};
            r_dig <= {adj[BCD_W-2:0], r_sh[iadp_pkg::DATA_W-1]};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_res.done   = r_done;
    assign o_res.top    = top;
    assign o_res.digits = r_dig;

endmodule

>>> rtl/integer_alu_decimal_print_unit.sv
// ============================================================================
// Integer ALU with decimal ASCII output
// Computes add, subtract, multiply, divide or modulo on signed 32-bit
// operands and prints the result as decimal text, one character per cycle.
// ============================================================================
// An item is accepted on a clock edge where start is high and busy is low.
// The block then raises busy until the closing newline has been sent.
// Each character appears on o_item for one cycle with o_strobe high; the
// closing newline carries last. The receiver cannot stall the output.
// Add and subtract pass through the shared adder in the fix and magnitude steps;
// multiply, divide and modulo go one bit per step through the same adder.
// The binary to decimal conversion then runs one bit per cycle.
// Text follows at one character per cycle, up to 12 characters for a number.
// A zero divisor skips the arithmetic and prints the stop message and a
// newline, up to 24 characters. An unknown operation prints only a newline.
// The next item can be accepted in the cycle after the newline.
// Reset returns the sequencer to idle and drops any item in flight.
// ============================================================================
module integer_alu_decimal_print_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  iadp_pkg::t_in  i_item,
    output logic           busy,
    output logic           o_strobe,
    output iadp_pkg::t_out o_item
);

    iadp_pkg::t_state          r_state, n_state;
    logic [iadp_pkg::IDX_W-1:0] r_idx, n_idx;
    logic                      r_is_mod, n_is_mod;
    logic                      r_neg, n_neg;

    iadp_pkg::t_ar_res         ar_res;
    iadp_pkg::t_bcd_res        bcd_res;
    logic                      accept, cmd_ok, zero_div, ar_go;
    logic [iadp_pkg::DIG_W-1:0] digit;

    assign accept   = start && (r_state == iadp_pkg::ST_IDLE);
    assign cmd_ok   = (i_item.cmd <= iadp_pkg::CMD_MOD);
    assign zero_div = (i_item.cmd inside {iadp_pkg::CMD_DIV, iadp_pkg::CMD_MOD})
                   && (i_item.right_operand == '0);
    assign ar_go    = accept && cmd_ok && !zero_div;
    assign digit    = bcd_res.digits[r_idx[iadp_pkg::DIG_W-1:0]*iadp_pkg::DIG_W +:
                                     iadp_pkg::DIG_W];

    iadp_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (ar_go),
        .i_item  (i_item),
        .o_res   (ar_res)
    );

    iadp_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (ar_res.done),
        .i_mag   (ar_res.mag),
        .o_res   (bcd_res)
    );

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_is_mod = r_is_mod;
        n_neg    = r_neg;
        case (r_state)
            iadp_pkg::ST_IDLE: begin
                n_idx    = '0;
                n_is_mod = (i_item.cmd == iadp_pkg::CMD_MOD);
                if (start) begin
                    if (!cmd_ok) begin
                        n_state = iadp_pkg::ST_NL;
                    end else if (zero_div) begin
                        n_state = iadp_pkg::ST_MSG;
                    end else begin
                        n_state = iadp_pkg::ST_ARITH;
                    end
                end
            end
            iadp_pkg::ST_ARITH: begin
                n_neg = ar_res.neg;
                if (ar_res.done) begin
                    n_state = iadp_pkg::ST_CONV;
                end
            end
            iadp_pkg::ST_CONV: begin
                n_idx = {1'b0, bcd_res.top};
                if (bcd_res.done) begin
                    n_state = r_neg ? iadp_pkg::ST_SIGN : iadp_pkg::ST_DIGIT;
                end
            end
            iadp_pkg::ST_SIGN: n_state = iadp_pkg::ST_DIGIT;
            iadp_pkg::ST_DIGIT: begin
                if (r_idx == '0) begin
                    n_state = iadp_pkg::ST_NL;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            iadp_pkg::ST_MSG: begin
                if (r_idx == iadp_pkg::msg_last(r_is_mod)) begin
                    n_state = iadp_pkg::ST_NL;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            iadp_pkg::ST_NL:   n_state = iadp_pkg::ST_IDLE;
            default:           n_state = iadp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_strobe        = 1'b0;
        o_item.out_char = iadp_pkg::CHAR_NEWLINE;
        o_item.last     = 1'b0;
        busy            = (r_state != iadp_pkg::ST_IDLE);
        case (r_state)
            iadp_pkg::ST_SIGN: begin
                o_strobe        = 1'b1;
                o_item.out_char = iadp_pkg::CHAR_MINUS;
            end
            iadp_pkg::ST_DIGIT: begin
                o_strobe        = 1'b1;
                o_item.out_char = iadp_pkg::CHAR_ZERO | {4'b0000, digit};
            end
            iadp_pkg::ST_MSG: begin
                o_strobe        = 1'b1;
                o_item.out_char = iadp_pkg::msg_char(r_is_mod, r_idx);
            end
            iadp_pkg::ST_NL: begin
                o_strobe        = 1'b1;
                o_item.last     = 1'b1;
            end
            default: begin
                o_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iadp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_is_mod <= n_is_mod;
        r_neg    <= n_neg;
    end

endmodule

>>> tb/sv/integer_alu_decimal_print_unit_test.sv
`timescale 1ns / 1ps
// ============================================================================
// Integer ALU decimal print unit testbench
// Sends operation items through the start/busy handshake and checks every
// printed character against a local prediction of the decimal text. A short
// table of directed items, most with hand-written text, is followed by random
// items under several patterns of sender idling. A watchdog ends a hung run.
// ============================================================================
module integer_alu_decimal_print_unit_test;

    localparam logic [2:0]  CMD_NONE_FIRST   = 3'd5;
    localparam logic [2:0]  CMD_NONE_LAST    = 3'd7;
    localparam logic [31:0] INT_MIN          = 32'h8000_0000;
    localparam logic [31:0] INT_MAX          = 32'h7FFF_FFFF;
    localparam string       DIV_STOP_TEXT    = "Stop : division by zero";
    localparam string       MOD_STOP_TEXT    = "Stop : modulo by zero";
    localparam int          RANDOM_PER_PHASE = 118;
    localparam int          DRAIN_CYCLES     = 120;
    localparam int          WATCHDOG_LIMIT   = 2000;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    iadp_pkg::t_in  i_item;
    logic           busy;
    logic           o_strobe;
    iadp_pkg::t_out o_item;

    iadp_pkg::t_out expected_chars[$];
    iadp_pkg::t_in  row_items[$];
    bit    row_typed[$];
    string row_text[$];
    int    mismatches   = 0;
    int    quiet_cycles = 0;

    integer_alu_decimal_print_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_item   (o_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic void queue_line(input string text);
        iadp_pkg::t_out ch;
        for (int i = 0; i < text.len(); i++) begin
            ch.out_char = text[i];
            ch.last     = 1'b0;
            expected_chars.push_back(ch);
        end
        ch.out_char = iadp_pkg::CHAR_NEWLINE;
        ch.last     = 1'b1;
        expected_chars.push_back(ch);
    endfunction

    function automatic void queue_decimal_text(input iadp_pkg::t_in it);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        logic [31:0] res;
        string       text;
        a     = it.left_operand;
        b     = it.right_operand;
        mag_a = a[31] ? -a : a;
        mag_b = b[31] ? -b : b;
        res   = '0;
        text  = "";
        case (it.cmd)
            iadp_pkg::CMD_ADD: res = a + b;
            iadp_pkg::CMD_SUB: res = a - b;
            iadp_pkg::CMD_MUL: res = a * b;
            iadp_pkg::CMD_DIV: begin
                if (b == '0) begin
                    text = DIV_STOP_TEXT;
                end else begin
                    res = mag_a / mag_b;
                    if (a[31] != b[31]) res = -res;
                end
            end
            iadp_pkg::CMD_MOD: begin
                if (b == '0) begin
                    text = MOD_STOP_TEXT;
                end else begin
                    res = mag_a % mag_b;
                    if (a[31]) res = -res;
                end
            end
            default: ;
        endcase
        if (it.cmd <= iadp_pkg::CMD_MOD && text == "") text = $sformatf("%0d", $signed(res));
        queue_line(text);
    endfunction

    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1: v = $urandom_range(0, 40) - 20;
            2: begin
                case ($urandom_range(0, 4))
                    0: v = INT_MIN;
                    1: v = INT_MAX;
                    2: v = '0;
                    3: v = '1;
                    default: v = 32'd1;
                endcase
            end
            3: v = $urandom_range(0, 99999);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic add_row(input logic [2:0] cmd, input logic [31:0] a, input logic [31:0] b,
                           input bit typed, input string text);
        iadp_pkg::t_in it;
        it.cmd           = cmd;
        it.left_operand  = a;
        it.right_operand = b;
        row_items.push_back(it);
        row_typed.push_back(typed);
        row_text.push_back(text);
    endtask

    // Holds start high until busy reads low, then queues its expected text.
    task automatic send_item(input iadp_pkg::t_in it, input bit typed, input string text);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        if (typed) queue_line(text);
        else queue_decimal_text(it);
    endtask

    always @(posedge i_clk) begin
        iadp_pkg::t_out want;
        if (i_rst_n && o_strobe) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected character 8'h%02h", o_item.out_char));
            end else begin
                want = expected_chars.pop_front();
                if (o_item.out_char !== want.out_char)
                    report_mismatch($sformatf("character got 8'h%02h, want 8'h%02h",
                                              o_item.out_char, want.out_char));
                if (o_item.last !== want.last)
                    report_mismatch($sformatf("last got %b, want %b on character 8'h%02h",
                                              o_item.last, want.last, want.out_char));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int            idle_pct [3];
        int            r;
        iadp_pkg::t_in it;
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_item   = '0;
        idle_pct = '{0, 49, 18};

        add_row(iadp_pkg::CMD_ADD, 32'd0, 32'd0, 1, "0");
        add_row(iadp_pkg::CMD_ADD, INT_MAX, 32'd1, 1, "-2147483648");
        add_row(iadp_pkg::CMD_ADD, INT_MIN, -32'sd1, 1, "2147483647");
        add_row(iadp_pkg::CMD_ADD, -32'sd1, -32'sd1, 1, "-2");
        add_row(iadp_pkg::CMD_SUB, 32'd0, INT_MIN, 1, "-2147483648");
        add_row(iadp_pkg::CMD_SUB, INT_MIN, 32'd1, 1, "2147483647");
        add_row(iadp_pkg::CMD_SUB, 32'd12345, 32'd678, 0, "");
        add_row(iadp_pkg::CMD_MUL, INT_MAX, INT_MAX, 1, "1");
        add_row(iadp_pkg::CMD_MUL, INT_MIN, -32'sd1, 1, "-2147483648");
        add_row(iadp_pkg::CMD_MUL, -32'sd7, 32'd6, 1, "-42");
        add_row(iadp_pkg::CMD_MUL, 32'd65536, 32'd65536, 1, "0");
        add_row(iadp_pkg::CMD_DIV, 32'd7, -32'sd2, 1, "-3");
        add_row(iadp_pkg::CMD_DIV, -32'sd7, 32'd2, 1, "-3");
        add_row(iadp_pkg::CMD_DIV, INT_MIN, -32'sd1, 1, "-2147483648");
        add_row(iadp_pkg::CMD_DIV, 32'd5, 32'd0, 1, DIV_STOP_TEXT);
        add_row(iadp_pkg::CMD_DIV, INT_MIN, INT_MAX, 1, "-1");
        add_row(iadp_pkg::CMD_DIV, 32'd1000000000, 32'd3, 0, "");
        add_row(iadp_pkg::CMD_MOD, -32'sd7, 32'd2, 1, "-1");
        add_row(iadp_pkg::CMD_MOD, 32'd7, -32'sd2, 1, "1");
        add_row(iadp_pkg::CMD_MOD, INT_MIN, -32'sd1, 1, "0");
        add_row(iadp_pkg::CMD_MOD, 32'd0, 32'd0, 1, MOD_STOP_TEXT);
        add_row(iadp_pkg::CMD_MOD, INT_MAX, INT_MIN, 1, "2147483647");
        add_row(CMD_NONE_FIRST, 32'd3, 32'd4, 1, "");
        add_row(CMD_NONE_FIRST + 3'd1, INT_MAX, 32'd0, 1, "");
        add_row(CMD_NONE_LAST, INT_MIN, -32'sd1, 1, "");

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < row_items.size(); k++)
            send_item(row_items[k], row_typed[k], row_text[k]);

        foreach (idle_pct[p]) begin
            repeat (RANDOM_PER_PHASE) begin
                if (idle_pct[p] != 0 && $urandom_range(0, 99) < idle_pct[p]) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 90)) @(posedge i_clk);
                end
                r = $urandom_range(0, 19);
                if (r < 17) it.cmd = 3'(r % 5);
                else it.cmd = 3'($urandom_range(CMD_NONE_FIRST, CMD_NONE_LAST));
                it.left_operand  = pick_operand();
                it.right_operand = pick_operand();
                send_item(it, 0, "");
            end
        end
        start <= 1'b0;

        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_chars.size() != 0)
            report_mismatch($sformatf("%0d characters never printed", expected_chars.size()));
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
